// ===== hw/rtl/sidp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_pkg
// Shared types and constants of the PSID/RSID header parser.
// ----------------------------------------------------------------------------
package sidp_pkg;

  // Byte position counter width; position saturates at its top value.
  localparam int POSITION_BITS = 17;

  // Result kinds
  localparam logic KIND_PROGRAM = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One input beat: a file byte and its end mark.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } sidp_item_t;

  // One result beat.
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  program_byte;
    logic [15:0] program_address;
    logic [15:0] init_address;
    logic [15:0] play_address;
    logic [15:0] song_count;
    logic [15:0] start_song;
    logic [1:0]  clock_code;
    logic        plays_cia;
    logic        is_rsid;
    logic [15:0] format_version;
    logic [2:0]  error_code;
  } sidp_result_t;

  // Results of one byte, pushed into the result queue together.
  typedef struct packed {
    logic [1:0]   beats;
    sidp_result_t first;
    sidp_result_t second;
  } sidp_push_t;

endpackage

// ===== hw/rtl/sidp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_parser
// Header field capture, program byte addressing and closing summary for one
// registered file byte per cycle while step is high.
// ----------------------------------------------------------------------------
module sidp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sidp_pkg::sidp_item_t item,
  output sidp_pkg::sidp_push_t push
);
  import sidp_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [31:0] HEADER_V1_LEN = 32'h76;
  localparam logic [31:0] FLAGS_END_LEN = 32'h78;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SHORT   = 3'd1;
  localparam logic [2:0] ERR_MAGIC   = 3'd2;
  localparam logic [2:0] ERR_VERSION = 3'd3;
  localparam logic [2:0] ERR_PAST    = 3'd4;
  localparam logic [2:0] ERR_NO_LOAD = 3'd5;
  localparam logic [2:0] ERR_NO_DATA = 3'd6;
  localparam logic [2:0] ERR_OFFSET  = 3'd7;

  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_D = 8'h44;

  typedef enum logic [1:0] {
    MAGIC_UNKNOWN,
    MAGIC_PSID,
    MAGIC_RSID,
    MAGIC_BAD
  } sidp_magic_t;

  // Expected magic tail character at positions 1..3
  function automatic logic [7:0] magic_tail(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd1:    c = CHAR_S;
      2'd2:    c = CHAR_I;
      2'd3:    c = CHAR_D;
      default: c = CHAR_P;
    endcase
    return c;
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] low16(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // State
  logic [POSITION_BITS-1:0] position;
  sidp_magic_t              magic;
  logic [15:0]              version_word;
  logic [15:0]              data_start;
  logic [15:0]              header_load;
  logic [15:0]              init_word;
  logic [15:0]              play_word;
  logic [15:0]              songs_word;
  logic [15:0]              start_word;
  logic [31:0]              speed_word;
  logic [15:0]              flags_word;
  logic [15:0]              eff_load;
  logic [POSITION_BITS-1:0] program_count;
  logic [2:0]               early_error;
  logic [7:0]               pending_byte;

  sidp_magic_t              magic_next;
  logic [15:0]              version_word_next;
  logic [15:0]              data_start_next;
  logic [15:0]              header_load_next;
  logic [15:0]              init_word_next;
  logic [15:0]              play_word_next;
  logic [15:0]              songs_word_next;
  logic [15:0]              start_word_next;
  logic [31:0]              speed_word_next;
  logic [15:0]              flags_word_next;
  logic [15:0]              eff_load_next;
  logic [POSITION_BITS-1:0] program_count_next;
  logic [2:0]               early_error_next;
  logic [7:0]               pending_byte_next;

  logic [31:0]              pe;
  logic [31:0]              len;
  logic [31:0]              idx;
  logic [7:0]               b;
  logic                     last;
  logic                     in_data;
  logic [1:0]               n_prog;
  logic [POSITION_BITS-1:0] pc1;
  logic [POSITION_BITS-1:0] pc2;
  logic [15:0]              songs;
  logic [15:0]              start;
  logic [4:0]               speed_sel;
  logic [2:0]               err;
  sidp_result_t             r0;
  sidp_result_t             r1;
  sidp_result_t             summary;

  always_comb begin
    pe   = 32'(position);
    len  = pe + 32'd1;
    b    = item.file_byte;
    last = item.last_byte;
    pc1  = sat_inc(program_count);
    pc2  = sat_inc(pc1);

    magic_next         = magic;
    version_word_next  = version_word;
    data_start_next    = data_start;
    header_load_next   = header_load;
    init_word_next     = init_word;
    play_word_next     = play_word;
    songs_word_next    = songs_word;
    start_word_next    = start_word;
    speed_word_next    = speed_word;
    flags_word_next    = flags_word;
    eff_load_next      = eff_load;
    program_count_next = program_count;
    early_error_next   = early_error;
    pending_byte_next  = pending_byte;

    // Header field capture by position
    if (pe == 32'd0) begin
      magic_next = (b == CHAR_P) ? MAGIC_PSID : (b == CHAR_R) ? MAGIC_RSID : MAGIC_BAD;
    end else if (pe <= 32'd3) begin
      if (b != magic_tail(pe[1:0])) magic_next = MAGIC_BAD;
      if (pe == 32'd3 && magic_next == MAGIC_BAD && early_error == ERR_NONE)
        early_error_next = ERR_MAGIC;
    end else if (pe <= 32'd5) begin
      version_word_next = {version_word[7:0], b};
      if (pe == 32'd5 && early_error == ERR_NONE &&
          (version_word_next < 16'd1 || version_word_next > 16'd4))
        early_error_next = ERR_VERSION;
    end else if (pe <= 32'd7) begin
      data_start_next = {data_start[7:0], b};
      if (pe == 32'd7 && early_error == ERR_NONE && data_start_next < 16'd8)
        early_error_next = ERR_OFFSET;
    end else if (pe <= 32'd9) begin
      header_load_next = {header_load[7:0], b};
      if (pe == 32'd9) eff_load_next = header_load_next;
    end else if (pe <= 32'd11) begin
      init_word_next = {init_word[7:0], b};
    end else if (pe <= 32'd13) begin
      play_word_next = {play_word[7:0], b};
    end else if (pe <= 32'd15) begin
      songs_word_next = {songs_word[7:0], b};
    end else if (pe <= 32'd17) begin
      start_word_next = {start_word[7:0], b};
    end else if (pe <= 32'd21) begin
      speed_word_next = {speed_word[23:0], b};
    end else if (pe == 32'h76 || pe == 32'h77) begin
      flags_word_next = {flags_word[7:0], b};
    end

    // Program data: embedded load address or emitted bytes
    r0       = '0;
    r1       = '0;
    n_prog   = 2'd0;
    idx      = pe - 32'(data_start);
    in_data  = (early_error == ERR_NONE) && (pe >= 32'd8) && (pe >= 32'(data_start));
    if (in_data) begin
      if (pe == 32'd8) begin
        pending_byte_next = b;
      end else if (pe == 32'd9 && data_start == 16'd8) begin
        if (header_load_next == 16'd0) begin
          eff_load_next = {b, pending_byte};
        end else begin
          r0.program_byte    = pending_byte;
          r0.program_address = eff_load_next + low16(program_count);
          program_count_next = pc1;
          n_prog             = 2'd1;
          if (!last) begin
            r1.program_byte    = b;
            r1.program_address = eff_load_next + low16(pc1);
            program_count_next = pc2;
            n_prog             = 2'd2;
          end
        end
      end else if (header_load_next == 16'd0 && idx == 32'd0) begin
        eff_load_next = {8'h00, b};
      end else if (header_load_next == 16'd0 && idx == 32'd1) begin
        eff_load_next = {b, eff_load_next[7:0]};
      end else begin
        r0.program_byte    = b;
        r0.program_address = eff_load_next + low16(program_count);
        program_count_next = pc1;
        n_prog             = 2'd1;
      end
    end

    // Closing summary
    songs     = (songs_word_next != 16'd0) ? songs_word_next : 16'd1;
    start     = (start_word_next == 16'd0 || start_word_next > songs) ? 16'd1 : start_word_next;
    speed_sel = 5'(start - 16'd1);
    priority if (len < HEADER_V1_LEN)                          err = ERR_SHORT;
    else if (early_error_next != ERR_NONE)                     err = early_error_next;
    else if (32'(data_start_next) > len)                       err = ERR_PAST;
    else if (header_load_next == 16'd0 &&
             (len - 32'(data_start_next)) < 32'd2)             err = ERR_NO_LOAD;
    else if (program_count_next == '0)                         err = ERR_NO_DATA;
    else                                                       err = ERR_NONE;

    summary                 = '0;
    summary.result_kind     = KIND_SUMMARY;
    summary.init_address    = (init_word_next != 16'd0) ? init_word_next : eff_load_next;
    summary.play_address    = play_word_next;
    summary.song_count      = songs;
    summary.start_song      = start;
    summary.clock_code      = (version_word_next >= 16'd2 && len >= FLAGS_END_LEN) ?
                              flags_word_next[3:2] : 2'd1;
    summary.plays_cia       = speed_word_next[speed_sel];
    summary.is_rsid         = (magic_next == MAGIC_RSID);
    summary.format_version  = version_word_next;
    summary.error_code      = err;

    // Order the beats: program bytes first, summary last
    push.beats  = n_prog + {1'b0, last};
    push.first  = (last && n_prog == 2'd0) ? summary : r0;
    push.second = (last && n_prog == 2'd1) ? summary : r1;
    if (!step) push.beats = 2'd0;
  end

  // State registers; a finished file returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      position      <= '0;
      magic         <= MAGIC_UNKNOWN;
      version_word  <= '0;
      data_start    <= '0;
      header_load   <= '0;
      init_word     <= '0;
      play_word     <= '0;
      songs_word    <= '0;
      start_word    <= '0;
      speed_word    <= '0;
      flags_word    <= '0;
      eff_load      <= '0;
      program_count <= '0;
      early_error   <= ERR_NONE;
      pending_byte  <= '0;
    end else if (step) begin
      position      <= sat_inc(position);
      magic         <= magic_next;
      version_word  <= version_word_next;
      data_start    <= data_start_next;
      header_load   <= header_load_next;
      init_word     <= init_word_next;
      play_word     <= play_word_next;
      songs_word    <= songs_word_next;
      start_word    <= start_word_next;
      speed_word    <= speed_word_next;
      flags_word    <= flags_word_next;
      eff_load      <= eff_load_next;
      program_count <= program_count_next;
      early_error   <= early_error_next;
      pending_byte  <= pending_byte_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A byte never yields more than two beats
  a_beats_max: assert property (@(posedge clk) disable iff (rst)
    push.beats != 2'd3)
    else $error("parser pushed three beats");

  // With two beats the summary, if any, is the second one
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    push.beats == 2'd2 |-> push.first.result_kind == KIND_PROGRAM)
    else $error("summary placed before a program byte");

  // The last byte of a file restarts the position count
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> position == '0)
    else $error("position not cleared after last byte");
`endif

endmodule

// ===== hw/rtl/sidp_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidp_result_fifo
// Four-entry result queue, up to two beats written and one read per cycle.
// ----------------------------------------------------------------------------
module sidp_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  sidp_pkg::sidp_push_t  push,
  output logic                  room,
  output logic                  result_valid,
  input  logic                  result_ready,
  output sidp_pkg::sidp_result_t result
);
  import sidp_pkg::*;

  localparam int AW    = 2;
  localparam int DEPTH = 1 << AW;

  sidp_result_t    mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic [AW:0]     count_next;
  logic            pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = (count != '0);
  assign result       = mem[rd_ptr];
  // Room for the worst case of two beats
  assign room         = (count <= (AW+1)'(DEPTH - 2));
  assign count_next   = count + (AW+1)'(push.beats) - (AW+1)'(pop);

  // Storage
  always_ff @(posedge clk) begin
    if (push.beats != 2'd0) mem[wr_ptr] <= push.first;
    if (push.beats == 2'd2) mem[wr_ptr + 1'b1] <= push.second;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.beats);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count  <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Fill level stays within the queue
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  // The parser only pushes when room was granted
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.beats != 2'd0 |-> room)
    else $error("push without room");
`endif

endmodule

// ===== hw/rtl/sid_music_file_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_music_file_header_parser
// Streaming PSID/RSID header parser: program bytes with addresses, then a
// closing summary per file.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while the queue has room. A byte is
// held in an input register; its results (none, one or two beats) go through
// a four-entry result queue. A byte is parsed whenever the queue has room for
// two beats; with the result side taking one beat per cycle the input runs at
// one byte per cycle, and the bytes that yield two beats (the last byte with
// its summary, or the held data byte at offset eight) each add one beat that
// the queue absorbs. After the last byte of a file the parser is back in its
// reset state and the next file may follow in the next cycle.
module sid_music_file_header_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  sidp_pkg::sidp_item_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output sidp_pkg::sidp_result_t result
);
  import sidp_pkg::*;

  logic         held;
  sidp_item_t   held_item;
  logic         room;
  logic         step;
  sidp_push_t   push;

  // Input register: parse when the queue can take the worst case
  assign step       = held && room;
  assign item_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) held_item <= item;
  end

  sidp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held_item),
    .push (push)
  );

  sidp_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming PSID/RSID header parser.
// ----------------------------------------------------------------------------
// Whole files are streamed into the parser one byte per beat. A behavioral
// parser inside the bench follows every accepted byte and queues the beats
// it should cause. A monitor compares every result beat, field by field,
// against the oldest queued beat. Coverage comes from hand-built files for
// each error path, randomized files (valid headers with random content plus
// broken ones), a long result-side hold-off, and one file long enough to
// saturate the position counter.
// ----------------------------------------------------------------------------
module testbench;
  import sidp_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_BYTES = 1650;
  localparam logic [31:0] POS_MAX      = (32'd1 << POSITION_BITS) - 32'd1;
  localparam logic [31:0] HDR_V1_LEN   = 32'h76;
  localparam logic [31:0] FLAGS_END    = 32'h78;
  localparam logic [31:0] TAG_PSID     = "PSID";
  localparam logic [31:0] TAG_RSID     = "RSID";
  localparam logic [23:0] TAG_TAIL     = "SID";

  // Magic classification
  localparam logic [1:0] MAGIC_UNKNOWN = 2'd0;
  localparam logic [1:0] MAGIC_PSID    = 2'd1;
  localparam logic [1:0] MAGIC_RSID    = 2'd2;
  localparam logic [1:0] MAGIC_BAD     = 2'd3;

  // Summary error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_SHORT      = 3'd1;
  localparam logic [2:0] ERR_MAGIC      = 3'd2;
  localparam logic [2:0] ERR_VERSION    = 3'd3;
  localparam logic [2:0] ERR_PAST_END   = 3'd4;
  localparam logic [2:0] ERR_NO_LOAD    = 3'd5;
  localparam logic [2:0] ERR_NO_DATA    = 3'd6;
  localparam logic [2:0] ERR_OFFSET_LOW = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_ready;
  sidp_item_t   item = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  sidp_result_t result;

  sid_music_file_header_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Parser state mirrored by the bench
  logic [31:0] pos_q;
  logic [1:0]  magic_q;
  logic [15:0] version_q;
  logic [15:0] offset_q;
  logic [15:0] hdr_load_q;
  logic [15:0] init_q;
  logic [15:0] play_q;
  logic [15:0] songs_q;
  logic [15:0] start_q;
  logic [31:0] speed_q;
  logic [15:0] flags_q;
  logic [15:0] load_q;
  logic [31:0] prog_count_q;
  logic [2:0]  early_err_q;
  logic [7:0]  held_byte_q;

  sidp_result_t expected_beats[$];
  logic [7:0]   file_bytes[$];

  // Run bookkeeping
  int          mismatch_count = 0;
  int          beats_checked  = 0;
  int          summaries_seen = 0;
  int          files_sent     = 0;
  int          bytes_sent     = 0;
  int          cycle_count    = 0;
  logic [7:0]  codes_seen     = '0;
  sidp_result_t want;

  // Sender and receiver pacing
  int   burst_left    = 0;
  bit   gaps_on       = 1'b1;
  bit   fast_receiver = 1'b0;
  int   hold_request  = 0;
  int   hold_taken    = 0;
  int   hold_left     = 0;
  int   stall_phase   = 0;
  int   stall_mode    = 0;

  // --------------------------------------------------------------------------
  // Behavioral parser
  // --------------------------------------------------------------------------
  task automatic clear_parser();
    pos_q = '0; magic_q = MAGIC_UNKNOWN; version_q = '0; offset_q = '0;
    hdr_load_q = '0; init_q = '0; play_q = '0; songs_q = '0; start_q = '0;
    speed_q = '0; flags_q = '0; load_q = '0; prog_count_q = '0;
    early_err_q = ERR_NONE; held_byte_q = '0;
  endtask

  task automatic queue_program_beat(input logic [7:0] b);
    sidp_result_t r;
    r = '0;
    r.result_kind     = KIND_PROGRAM;
    r.program_byte    = b;
    r.program_address = load_q + prog_count_q[15:0];
    if (prog_count_q < POS_MAX) prog_count_q++;
    expected_beats.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] p;
    logic [31:0] len;
    logic [31:0] idx;
    logic [15:0] songs;
    logic [15:0] start;
    logic [2:0]  err;
    sidp_result_t s;
    p = pos_q;

    // Header field capture
    if (p == 0) begin
      magic_q = (b == "P") ? MAGIC_PSID : (b == "R") ? MAGIC_RSID : MAGIC_BAD;
    end else if (p <= 3) begin
      if (b != TAG_TAIL[8*(3-p) +: 8]) magic_q = MAGIC_BAD;
      if (p == 3 && magic_q == MAGIC_BAD && early_err_q == ERR_NONE)
        early_err_q = ERR_MAGIC;
    end else if (p <= 5) begin
      version_q = {version_q[7:0], b};
      if (p == 5 && early_err_q == ERR_NONE && (version_q < 1 || version_q > 4))
        early_err_q = ERR_VERSION;
    end else if (p <= 7) begin
      offset_q = {offset_q[7:0], b};
      if (p == 7 && early_err_q == ERR_NONE && offset_q < 8)
        early_err_q = ERR_OFFSET_LOW;
    end else if (p <= 9) begin
      hdr_load_q = {hdr_load_q[7:0], b};
      if (p == 9) load_q = hdr_load_q;
    end else if (p <= 11) begin
      init_q = {init_q[7:0], b};
    end else if (p <= 13) begin
      play_q = {play_q[7:0], b};
    end else if (p <= 15) begin
      songs_q = {songs_q[7:0], b};
    end else if (p <= 17) begin
      start_q = {start_q[7:0], b};
    end else if (p <= 21) begin
      speed_q = {speed_q[23:0], b};
    end else if (p == HDR_V1_LEN || p == HDR_V1_LEN + 1) begin
      flags_q = {flags_q[7:0], b};
    end

    // Program data
    if (early_err_q == ERR_NONE && p >= 8 && p >= offset_q) begin
      if (p == 8) begin
        held_byte_q = b;
      end else if (p == 9 && offset_q == 8) begin
        if (hdr_load_q == 0) begin
          load_q = {b, held_byte_q};
        end else begin
          queue_program_beat(held_byte_q);
          if (!last) queue_program_beat(b);
        end
      end else begin
        idx = p - offset_q;
        if (hdr_load_q == 0 && idx == 0) load_q = {8'h00, b};
        else if (hdr_load_q == 0 && idx == 1) load_q = {b, load_q[7:0]};
        else queue_program_beat(b);
      end
    end

    // Closing summary
    if (last) begin
      len   = p + 1;
      songs = (songs_q != 0) ? songs_q : 16'd1;
      start = (start_q == 0 || start_q > songs) ? 16'd1 : start_q;
      if (len < HDR_V1_LEN) err = ERR_SHORT;
      else if (early_err_q != ERR_NONE) err = early_err_q;
      else if (offset_q > len) err = ERR_PAST_END;
      else if (hdr_load_q == 0 && len - offset_q < 2) err = ERR_NO_LOAD;
      else if (prog_count_q == 0) err = ERR_NO_DATA;
      else err = ERR_NONE;
      s = '0;
      s.result_kind    = KIND_SUMMARY;
      s.init_address   = (init_q != 0) ? init_q : load_q;
      s.play_address   = play_q;
      s.song_count     = songs;
      s.start_song     = start;
      s.clock_code     = (version_q >= 2 && len >= FLAGS_END) ? flags_q[3:2] : 2'd1;
      s.plays_cia      = speed_q[5'(start - 16'd1)];
      s.is_rsid        = (magic_q == MAGIC_RSID);
      s.format_version = version_q;
      s.error_code     = err;
      codes_seen[err]  = 1'b1;
      expected_beats.push_back(s);
      clear_parser();
    end else if (pos_q < POS_MAX) begin
      pos_q++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      beats_checked++;
      if (result.result_kind == KIND_SUMMARY) summaries_seen++;
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t: unexpected beat, expected none got %h", $time, result);
      end else begin
        want = expected_beats.pop_front();
        check_field("result_kind", want.result_kind, result.result_kind);
        check_field("program_byte", want.program_byte, result.program_byte);
        check_field("program_address", want.program_address, result.program_address);
        check_field("init_address", want.init_address, result.init_address);
        check_field("play_address", want.play_address, result.play_address);
        check_field("song_count", want.song_count, result.song_count);
        check_field("start_song", want.start_song, result.start_song);
        check_field("clock_code", want.clock_code, result.clock_code);
        check_field("plays_cia", want.plays_cia, result.plays_cia);
        check_field("is_rsid", want.is_rsid, result.is_rsid);
        check_field("format_version", want.format_version, result.format_version);
        check_field("error_code", want.error_code, result.error_code);
      end
    end
  end

  // Result-side stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_taken != hold_request) begin
      hold_taken   <= hold_request;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (fast_receiver) begin
      result_ready <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        stall_phase <= $urandom_range(20, 200);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: begin
          result_ready <= 1'b1;
        end
        1: begin
          result_ready <= $urandom_range(0, 1);
        end
        2: begin
          result_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          result_ready <= ($urandom_range(0, 7) != 0);
        end
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one byte; bursts of beats are separated by random gaps.
  task automatic send_byte(input logic [7:0] b, input logic last);
    sidp_item_t beat;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    beat.file_byte = b;
    beat.last_byte = last;
    item       <= beat;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    bytes_sent++;
    parse_byte(b, last);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  // Lower valid, then wait for every queued beat to come back.
  task automatic drain();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Lay out a file: header words big-endian, random filler and data.
  task automatic build_file(input logic [31:0] tag, input logic [15:0] version,
                            input logic [15:0] offset, input logic [15:0] load,
                            input logic [15:0] init, input logic [15:0] play,
                            input logic [15:0] songs, input logic [15:0] start,
                            input logic [31:0] speed, input logic [15:0] flags,
                            input int length);
    logic [7:0] hdr[0:119];
    for (int i = 0; i < 120; i++) hdr[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) hdr[i] = tag[8*(3-i) +: 8];
    {hdr[4], hdr[5]}   = version;
    {hdr[6], hdr[7]}   = offset;
    {hdr[8], hdr[9]}   = load;
    {hdr[10], hdr[11]} = init;
    {hdr[12], hdr[13]} = play;
    {hdr[14], hdr[15]} = songs;
    {hdr[16], hdr[17]} = start;
    {hdr[18], hdr[19], hdr[20], hdr[21]} = speed;
    {hdr[118], hdr[119]} = flags;
    file_bytes.delete();
    for (int i = 0; i < length; i++)
      file_bytes.push_back((i < 120) ? hdr[i] : 8'($urandom));
  endtask

  task automatic random_file();
    logic [31:0] tag;
    logic [15:0] version;
    logic [15:0] offset;
    logic [15:0] load;
    logic [15:0] init;
    logic [15:0] songs;
    logic [15:0] start;
    int          length;
    int          r;
    r = $urandom_range(0, 19);
    if (r < 9) tag = TAG_PSID;
    else if (r < 18) tag = TAG_RSID;
    else if (r == 18) tag = TAG_PSID ^ (32'd1 << $urandom_range(0, 31));
    else tag = $urandom;
    r = $urandom_range(0, 19);
    if (r < 17) version = 16'($urandom_range(1, 4));
    else if (r == 17) version = 16'd0;
    else if (r == 18) version = 16'($urandom_range(5, 16'hFFFF));
    else version = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1: offset = 16'h76;
      2, 3: offset = 16'h7C;
      4: offset = 16'd8;
      5: offset = 16'($urandom_range(9, 16'h75));
      6: offset = 16'($urandom_range(0, 7));
      7: offset = 16'($urandom_range(16'h78, 16'hA0));
      8: offset = 16'($urandom_range(16'h100, 16'hFFFF));
      default: offset = 16'($urandom);
    endcase
    r = $urandom_range(0, 9);
    load  = (r < 5) ? 16'h0 : (r == 5) ? 16'($urandom_range(16'hFFF0, 16'hFFFF)) :
            16'($urandom);
    init  = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
    r = $urandom_range(0, 9);
    songs = (r < 2) ? 16'h0 : (r < 7) ? 16'($urandom_range(1, 40)) : 16'($urandom);
    r = $urandom_range(0, 9);
    start = (r < 2) ? 16'h0 : (r < 7) ? 16'($urandom_range(1, 42)) : 16'($urandom);
    if ($urandom_range(0, 3) == 0) length = $urandom_range(1, 16'h90);
    else if (offset > 16'hA0) length = $urandom_range(16'h76, 16'hC0);
    else length = ((offset > 16'h76) ? offset : 16'h76) + $urandom_range(0, 24);
    build_file(tag, version, offset, load, init, 16'($urandom), songs, start,
               $urandom, 16'($urandom), length);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Tiny files: one byte, the held byte at offset eight cut off at position
  // nine, embedded load word cut off, and extreme byte values.
  task automatic test_tiny_files();
    build_file(TAG_PSID, 16'd2, 16'd8, 16'h1234, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 1);
    send_file();
    build_file(TAG_PSID, 16'd2, 16'd8, 16'h1234, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 10);
    send_file();
    build_file(TAG_RSID, 16'd3, 16'd8, 16'h0, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 10);
    send_file();
    file_bytes.delete();
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    send_file();
    drain();
  endtask

  // Full-length files steering the summary through each error code but ERR_SHORT
  // and the special load address paths.
  task automatic test_error_codes();
    build_file(TAG_PSID, 16'd2, 16'h7C, 16'h1000, 16'h1003, 16'h1006, 16'd3,
               16'd2, 32'h0000_0002, 16'h0008, 16'h80);
    send_file();
    build_file("PSIX", 16'd2, 16'h7C, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h80);
    send_file();
    build_file(TAG_RSID, 16'd0, 16'h7C, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h80);
    send_file();
    build_file(TAG_PSID, 16'd5, 16'h7C, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h80);
    send_file();
    build_file(TAG_PSID, 16'd2, 16'd4, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h80);
    send_file();
    build_file(TAG_PSID, 16'd2, 16'h200, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h80);
    send_file();
    build_file(TAG_RSID, 16'd4, 16'h7C, 16'h0, 16'h0, 16'h0, 16'd0, 16'd9,
               32'hFFFF_FFFF, 16'h000C, 16'h7D);
    send_file();
    build_file(TAG_PSID, 16'd2, 16'h7C, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h7C);
    send_file();
    // Offset of eight, embedded load word, then the held-byte pair
    build_file(TAG_PSID, 16'd2, 16'd8, 16'h0, 16'h0, 16'h0, 16'd40, 16'd33,
               32'h8000_0000, 16'h0004, 16'h80);
    send_file();
    build_file(TAG_PSID, 16'd3, 16'd8, 16'h2000, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF,
               32'h5555_5555, 16'hFFFF, 16'h80);
    send_file();
    // Version one of exact minimum length, no data: clock forced to PAL
    build_file(TAG_PSID, 16'd1, 16'h76, 16'h1000, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h76);
    send_file();
    // Address wrap past the top of memory
    build_file(TAG_PSID, 16'd2, 16'h7C, 16'hFFF0, 16'h0, 16'h0, 16'd1, 16'd1,
               32'h0, 16'h0, 16'h7C + 40);
    send_file();
    drain();
  endtask

  task automatic test_random_files();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      random_file();
      send_file();
    end
    drain();
  endtask

  // Result side holds off while bytes keep coming: the queue fills and the
  // input side must stall.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request++;
    for (int i = 0; i < 2; i++) begin
      random_file();
      send_file();
    end
    gaps_on = 1'b1;
    drain();
  endtask

  // One file past the position counter range; both counters must saturate.
  task automatic test_long_file();
    fast_receiver = 1'b1;
    gaps_on       = 1'b0;
    build_file(TAG_PSID, 16'd2, 16'h7C, 16'hC000, 16'h0, 16'h0, 16'd2, 16'd2,
               32'h0000_0002, 16'h0008, int'(POS_MAX) + 301);
    send_file();
    drain();
    fast_receiver = 1'b0;
    gaps_on       = 1'b1;
  endtask

  initial begin
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tiny_files();
    test_error_codes();
    test_random_files();
    test_backpressure();
    test_long_file();
    $display("Covered %0d files, %0d bytes, %0d result beats (%0d summaries)",
             files_sent, bytes_sent, beats_checked, summaries_seen);
    $display("Error codes reported (bit per code): %b, field mismatches: %0d",
             codes_seen, mismatch_count);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sidp_pkg.sv
hw/rtl/sidp_parser.sv
hw/rtl/sidp_result_fifo.sv
hw/rtl/sid_music_file_header_parser.sv
dv/testbench.sv
